@@ rtl/ndr_pkg.sv @@
`timescale 1ns / 1ps
// ndr_pkg: shared types and constants of the nack dedup receiver
// no dependencies

package ndr_pkg;

    localparam int SEQ_SPACE_DEF     = 65536;
    localparam int BATCH_MAX_DEF     = 32;
    localparam int PAYLOAD_BYTES_DEF = 160;

    // request codes
    localparam logic REQ_DATAGRAM = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    // result kinds
    localparam logic KIND_FWD  = 1'b0;
    localparam logic KIND_NACK = 1'b1;

    // register indexes
    localparam logic [2:0] REG_PLAYOUT = 3'd0;
    localparam logic [2:0] REG_PERIOD  = 3'd1;
    localparam logic [2:0] REG_MIN_RTT = 3'd2;
    localparam logic [2:0] REG_RENACK  = 3'd3;
    localparam logic [2:0] REG_MAX_NK  = 3'd4;
    localparam logic [2:0] REG_BATCH   = 3'd5;
    localparam logic [2:0] REG_BUDGET  = 3'd6;

    // register reset values
    localparam logic [19:0] PLAYOUT_RST = 20'd60000;
    localparam logic [15:0] PERIOD_RST  = 16'd20000;
    localparam logic [19:0] MIN_RTT_RST = 20'd10000;
    localparam logic [19:0] RENACK_RST  = 20'd30000;
    localparam logic [2:0]  MAX_NK_RST  = 3'd4;
    localparam logic [5:0]  BATCH_RST   = 6'd32;
    localparam logic [15:0] BUDGET_RST  = 16'd320;

    localparam int CFG_W = 20;

    typedef struct packed {
        logic        req_type;
        logic [11:0] datagram_len;
        logic [15:0] seq;
        logic [31:0] now_us;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] out_seq;
        logic [5:0]  nack_count;
        logic        last;
    } out_word_t;

    // per-sequence info entry: seen flag and nack counter
    typedef struct packed {
        logic       seen;
        logic [2:0] cnt;
    } seq_info_t;

    // command to the per-sequence store
    typedef struct packed {
        logic        rd_en;
        logic        info_we;
        logic        time_we;
        logic [15:0] addr;
        seq_info_t   info;
        logic [31:0] stamp;
    } mem_cmd_t;

endpackage

@@ rtl/ndr_store.sv @@
`timescale 1ns / 1ps
// ndr_store: per-sequence info memory (seen + counter) and nack time memory
// depends on ndr_pkg; info memory is swept to zero after reset

module ndr_store #(
    parameter int SEQ_SPACE = ndr_pkg::SEQ_SPACE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ndr_pkg::mem_cmd_t  cmd,
    output ndr_pkg::seq_info_t info_q,
    output logic [31:0]        stamp_q,
    output logic               clr_busy
);

    localparam int SEQ_W = $clog2(SEQ_SPACE);

    ndr_pkg::seq_info_t info_mem [SEQ_SPACE];
    logic [31:0]        stamp_mem [SEQ_SPACE];

    logic [SEQ_W-1:0] clr_addr_reg;
    logic             clr_busy_reg;
    logic [SEQ_W-1:0] addr;

    assign addr     = cmd.addr[SEQ_W-1:0];
    assign clr_busy = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == SEQ_W'(SEQ_SPACE - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            info_mem[clr_addr_reg] <= '0;
        end else if (cmd.info_we) begin
            info_mem[addr] <= cmd.info;
        end
        if (cmd.rd_en) begin
            info_q <= info_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.time_we) begin
            stamp_mem[addr] <= cmd.stamp;
        end
        if (cmd.rd_en) begin
            stamp_q <= stamp_mem[addr];
        end
    end

endmodule

@@ rtl/nack_dedup_receiver_top.sv @@
`timescale 1ns / 1ps
// nack_dedup_receiver_top: datagram dedup and nack scan sequencer
// depends on ndr_pkg and ndr_store

// channel   direction  handshake          word
// s_        in         s_valid / s_ready  ndr_pkg::in_word_t
// m_        out        m_valid / m_ready  ndr_pkg::out_word_t
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// after reset the info memory is swept with s_ready low
// datagram: read in D_RD, then checked in D_CHK and dropped or forwarded via O_WAIT
// tick: setup in T_MUL and T_RHS, per scanned sequence number one store read (S_RD)
// and one compare (S_CHK), budget in B_MUL and B_CMP, per nack word O_RD, O_LOAD, O_WAIT
// s_ready is high only in idle; the result word waits in m_word until taken

module nack_dedup_receiver_top #(
    parameter int SEQ_SPACE     = ndr_pkg::SEQ_SPACE_DEF,
    parameter int BATCH_MAX     = ndr_pkg::BATCH_MAX_DEF,
    parameter int PAYLOAD_BYTES = ndr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ndr_pkg::in_word_t          s_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ndr_pkg::out_word_t         m_word,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [ndr_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int SEQ_W  = $clog2(SEQ_SPACE);
    localparam int CNT_W  = $clog2(BATCH_MAX + 1);
    localparam int BIDX_W = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam logic [11:0] GOOD_LEN = 12'(PAYLOAD_BYTES + 2);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_D_RD   = 4'd1;
    localparam logic [3:0] ST_D_CHK  = 4'd2;
    localparam logic [3:0] ST_T_MUL  = 4'd3;
    localparam logic [3:0] ST_T_RHS  = 4'd4;
    localparam logic [3:0] ST_S_RD   = 4'd5;
    localparam logic [3:0] ST_S_CHK  = 4'd6;
    localparam logic [3:0] ST_B_MUL  = 4'd7;
    localparam logic [3:0] ST_B_CMP  = 4'd8;
    localparam logic [3:0] ST_O_RD   = 4'd9;
    localparam logic [3:0] ST_O_LOAD = 4'd10;
    localparam logic [3:0] ST_O_WAIT = 4'd11;

    // configuration registers
    logic [19:0] playout_reg;
    logic [15:0] period_reg;
    logic [19:0] min_rtt_reg;
    logic [19:0] renack_reg;
    logic [2:0]  max_nk_reg;
    logic [5:0]  batch_reg;
    logic [15:0] budget_reg;

    // control and scan state
    logic [3:0]       state_reg, state_next;
    ndr_pkg::in_word_t item_reg, item_next;
    logic [SEQ_W-1:0] highest_reg, highest_next;
    logic             any_reg, any_next;
    logic [SEQ_W-1:0] base_reg, base_next;
    logic [31:0]      fb_reg, fb_next;
    logic [SEQ_W-1:0] j_reg, j_next;
    logic             phase_reg, phase_next;  // 0 advance base, 1 gather
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [32:0]      lhs_reg, lhs_next;
    logic [33:0]      rhs_reg, rhs_next;
    logic [31:0]      prod_reg, prod_next;
    logic [39:0]      need_reg, need_next;
    logic [39:0]      allow_reg, allow_next;
    logic             m_valid_reg, m_valid_next;
    ndr_pkg::out_word_t m_word_reg, m_word_next;

    // batch buffer
    logic [15:0]       batch_mem [BATCH_MAX];
    logic [15:0]       batch_q;
    logic              batch_we;

    ndr_pkg::mem_cmd_t  cmd;
    ndr_pkg::seq_info_t info_q;
    logic [31:0]        stamp_q;
    logic               clr_busy;

    logic [SEQ_W-1:0] seq_in;
    logic [CNT_W-1:0] limit;
    logic             done_hit;
    logic             expired;
    logic             resting;
    logic signed [32:0] age;
    logic [8:0]       msg_len;

    ndr_store #(
        .SEQ_SPACE(SEQ_SPACE)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .info_q   (info_q),
        .stamp_q  (stamp_q),
        .clr_busy (clr_busy)
    );

    assign s_ready = (state_reg == ST_IDLE) && !clr_busy;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    assign seq_in = item_reg.seq[SEQ_W-1:0];
    assign limit  = (32'(batch_reg) > 32'(BATCH_MAX)) ? CNT_W'(BATCH_MAX)
                                                       : CNT_W'(batch_reg);
    // hole is settled: already received or out of nacks
    assign done_hit = info_q.seen || (info_q.cnt >= max_nk_reg);
    // too close to its deadline to be repaired
    assign expired  = {1'b0, lhs_reg} >= rhs_reg;
    assign age      = $signed({1'b0, item_reg.now_us}) - $signed({1'b0, stamp_q});
    assign resting  = (info_q.cnt != 3'd0) && (age < $signed({13'd0, renack_reg}));
    assign msg_len  = 9'd3 + 9'({cnt_reg, 2'b00});

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playout_reg <= ndr_pkg::PLAYOUT_RST;
            period_reg  <= ndr_pkg::PERIOD_RST;
            min_rtt_reg <= ndr_pkg::MIN_RTT_RST;
            renack_reg  <= ndr_pkg::RENACK_RST;
            max_nk_reg  <= ndr_pkg::MAX_NK_RST;
            batch_reg   <= ndr_pkg::BATCH_RST;
            budget_reg  <= ndr_pkg::BUDGET_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ndr_pkg::REG_PLAYOUT: playout_reg <= cfg_wdata;
                ndr_pkg::REG_PERIOD:  period_reg  <= cfg_wdata[15:0];
                ndr_pkg::REG_MIN_RTT: min_rtt_reg <= cfg_wdata;
                ndr_pkg::REG_RENACK:  renack_reg  <= cfg_wdata;
                ndr_pkg::REG_MAX_NK:  max_nk_reg  <= cfg_wdata[2:0];
                ndr_pkg::REG_BATCH:   batch_reg   <= cfg_wdata[5:0];
                ndr_pkg::REG_BUDGET:  budget_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        highest_next = highest_reg;
        any_next     = any_reg;
        base_next    = base_reg;
        fb_next      = fb_reg;
        j_next       = j_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        lhs_next     = lhs_reg;
        rhs_next     = rhs_reg;
        prod_next    = prod_reg;
        need_next    = need_reg;
        allow_next   = allow_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        batch_we     = 1'b0;
        cmd          = '0;
        cmd.addr     = 16'(j_reg);
        cmd.stamp    = item_reg.now_us;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_word;
                    if (s_word.req_type == ndr_pkg::REQ_DATAGRAM) begin
                        state_next = (s_word.datagram_len == GOOD_LEN) ? ST_D_RD
                                                                       : ST_IDLE;
                    end else begin
                        state_next = any_reg ? ST_T_MUL : ST_IDLE;
                    end
                end
            end
            ST_D_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = 16'(seq_in);
                state_next = ST_D_CHK;
            end
            ST_D_CHK: begin
                cmd.addr = 16'(seq_in);
                if (info_q.seen) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.info_we   = 1'b1;
                    cmd.info.seen = 1'b1;
                    cmd.info.cnt  = info_q.cnt;
                    if (!any_reg || seq_in > highest_reg) begin
                        highest_next = seq_in;
                        any_next     = 1'b1;
                    end
                    m_word_next.kind       = ndr_pkg::KIND_FWD;
                    m_word_next.out_seq    = 16'(seq_in);
                    m_word_next.nack_count = 6'd0;
                    m_word_next.last       = 1'b1;
                    m_valid_next           = 1'b1;
                    state_next             = ST_O_WAIT;
                end
            end
            ST_T_MUL: begin
                prod_next  = 32'(base_reg) * 32'(period_reg);
                lhs_next   = 33'(item_reg.now_us) + 33'(min_rtt_reg);
                state_next = ST_T_RHS;
            end
            ST_T_RHS: begin
                rhs_next   = 34'(playout_reg) + 34'(prod_reg);
                j_next     = base_reg;
                phase_next = 1'b0;
                cnt_next   = '0;
                state_next = ST_S_RD;
            end
            ST_S_RD: begin
                if (j_reg >= highest_reg || (phase_reg && cnt_reg >= limit)) begin
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_B_MUL;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_S_CHK;
                end
            end
            ST_S_CHK: begin
                state_next = ST_S_RD;
                if (!phase_reg) begin
                    if (done_hit || expired) begin
                        j_next    = j_reg + 1'b1;
                        base_next = j_reg + 1'b1;
                        rhs_next  = rhs_reg + 34'(period_reg);
                    end else begin
                        // first live hole: gather from here, same position
                        phase_next = 1'b1;
                    end
                end else begin
                    j_next   = j_reg + 1'b1;
                    rhs_next = rhs_reg + 34'(period_reg);
                    if (!done_hit && !expired && !resting) begin
                        cmd.info_we   = 1'b1;
                        cmd.info.seen = 1'b0;
                        cmd.info.cnt  = info_q.cnt + 3'd1;
                        cmd.time_we   = 1'b1;
                        batch_we      = 1'b1;
                        cnt_next      = cnt_reg + 1'b1;
                    end
                end
            end
            ST_B_MUL: begin
                need_next  = 40'(33'(fb_reg) + 33'(msg_len)) * 40'd100;
                allow_next = 40'(budget_reg) * 40'(33'(highest_reg) + 33'd1);
                state_next = ST_B_CMP;
            end
            ST_B_CMP: begin
                if (need_reg > allow_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    fb_next    = fb_reg + 32'(msg_len);
                    k_next     = '0;
                    state_next = ST_O_RD;
                end
            end
            ST_O_RD: begin
                // batch buffer read at k lands in batch_q
                state_next = ST_O_LOAD;
            end
            ST_O_LOAD: begin
                m_word_next.kind       = ndr_pkg::KIND_NACK;
                m_word_next.out_seq    = batch_q;
                m_word_next.nack_count = 6'(cnt_reg);
                m_word_next.last       = (k_reg + 1'b1 == cnt_reg);
                m_valid_next           = 1'b1;
                state_next             = ST_O_WAIT;
            end
            ST_O_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_word_reg.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_O_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            highest_reg <= '0;
            any_reg     <= 1'b0;
            base_reg    <= '0;
            fb_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            highest_reg <= highest_next;
            any_reg     <= any_next;
            base_reg    <= base_next;
            fb_reg      <= fb_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        j_reg      <= j_next;
        phase_reg  <= phase_next;
        k_reg      <= k_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        prod_reg   <= prod_next;
        need_reg   <= need_next;
        allow_reg  <= allow_next;
        m_word_reg <= m_word_next;
    end

    // batch buffer: written while gathering, read while sending
    always_ff @(posedge aclk) begin
        if (batch_we) begin
            batch_mem[cnt_reg[BIDX_W-1:0]] <= 16'(j_reg);
        end
        batch_q <= batch_mem[k_reg[BIDX_W-1:0]];
    end

`ifndef SYNTHESIS
    // a result word is only offered from the output wait state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == ST_O_WAIT)
        else $error("m_valid outside output wait");

    // gathering never overruns the batch buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(BATCH_MAX) || state_reg == ST_IDLE
        || state_reg == ST_D_RD || state_reg == ST_D_CHK)
        else $error("batch count overrun");

    // no item is taken while the info memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input ready during clear sweep");

    // the final word of an item returns the block to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_word.last) |=> state_reg == ST_IDLE)
        else $error("no return to idle after last word");
`endif

endmodule

@@ verif/ndr_checker.sv @@
`timescale 1ns / 1ps
// ndr_checker: watches the input, result and register ports of the nack dedup receiver,
// predicts every result word and compares it with what the block gives
// depends on ndr_pkg

module ndr_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  ndr_pkg::in_word_t         s_word,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  ndr_pkg::out_word_t        m_word,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [ndr_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      drain,
    output int                        fail_count,
    output int                        pending,
    output int                        words_seen
);

    localparam int SPACE = 65536;

    // shadow registers
    logic [19:0] playout;
    logic [15:0] period;
    logic [19:0] min_rtt;
    logic [19:0] renack;
    logic [2:0]  max_nk;
    logic [5:0]  batch;
    logic [15:0] budget;

    // shadow state
    bit          seen     [SPACE];
    bit   [2:0]  nk_cnt   [SPACE];
    bit   [31:0] nk_stamp [SPACE];
    logic [15:0] top_seq;
    bit          got_any;
    logic [15:0] base;
    logic [31:0] fb_bytes;

    ndr_pkg::out_word_t expected_words [$];
    bit          drained;

    assign pending = expected_words.size();

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic bit past_deadline(input int unsigned s, input logic [31:0] now);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = longint'(now) + longint'(min_rtt);
        rhs = longint'(playout) + longint'(s) * longint'(period);
        return lhs >= rhs;
    endfunction

    function automatic bit resolved(input int unsigned s);
        return seen[s] || nk_cnt[s] >= max_nk;
    endfunction

    task automatic predict_words(input ndr_pkg::in_word_t w);
        int unsigned    lim;
        int unsigned    cnt;
        int unsigned    picked [32];
        longint unsigned len;
        ndr_pkg::out_word_t o;
        if (w.req_type == ndr_pkg::REQ_DATAGRAM) begin
            if (w.datagram_len != 12'(ndr_pkg::PAYLOAD_BYTES_DEF + 2) || seen[w.seq]) return;
            seen[w.seq] = 1;
            if (!got_any || w.seq > top_seq) begin
                top_seq = w.seq;
                got_any = 1;
            end
            o.kind = ndr_pkg::KIND_FWD;
            o.out_seq = w.seq;
            o.nack_count = 6'd0;
            o.last = 1;
            expected_words.push_back(o);
            return;
        end
        if (!got_any) return;
        while (base < top_seq && (resolved(base) || past_deadline(base, w.now_us)))
            base++;
        lim = (batch < ndr_pkg::BATCH_MAX_DEF) ? batch : ndr_pkg::BATCH_MAX_DEF;
        cnt = 0;
        for (int unsigned j = base; j < top_seq && cnt < lim; j++) begin
            if (resolved(j) || past_deadline(j, w.now_us)) continue;
            // hole still inside its re-nack rest time
            if (nk_cnt[j] > 0 &&
                longint'(w.now_us) - longint'(nk_stamp[j]) < longint'(renack)) continue;
            picked[cnt] = j;
            nk_cnt[j]++;
            nk_stamp[j] = w.now_us;
            cnt++;
        end
        if (cnt == 0) return;
        len = 3 + 4 * longint'(cnt);
        if ((longint'(fb_bytes) + len) * 100 > longint'(budget) * (longint'(top_seq) + 1))
            return;
        fb_bytes += 32'(len);
        for (int unsigned k = 0; k < cnt; k++) begin
            o.kind = ndr_pkg::KIND_NACK;
            o.out_seq = 16'(picked[k]);
            o.nack_count = 6'(cnt);
            o.last = (k + 1 == cnt);
            expected_words.push_back(o);
        end
    endtask

    initial begin
        fail_count = 0;
        words_seen = 0;
        drained = 0;
    end

    always @(posedge aclk) begin
        ndr_pkg::out_word_t want;
        if (!aresetn) begin
            playout = ndr_pkg::PLAYOUT_RST;
            period = ndr_pkg::PERIOD_RST;
            min_rtt = ndr_pkg::MIN_RTT_RST;
            renack = ndr_pkg::RENACK_RST;
            max_nk = ndr_pkg::MAX_NK_RST;
            batch = ndr_pkg::BATCH_RST;
            budget = ndr_pkg::BUDGET_RST;
            for (int i = 0; i < SPACE; i++) begin
                seen[i] = 0;
                nk_cnt[i] = 0;
                nk_stamp[i] = 0;
            end
            top_seq = 0;
            got_any = 0;
            base = 0;
            fb_bytes = 0;
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ndr_pkg::REG_PLAYOUT: playout = cfg_wdata[19:0];
                    ndr_pkg::REG_PERIOD:  period = cfg_wdata[15:0];
                    ndr_pkg::REG_MIN_RTT: min_rtt = cfg_wdata[19:0];
                    ndr_pkg::REG_RENACK:  renack = cfg_wdata[19:0];
                    ndr_pkg::REG_MAX_NK:  max_nk = cfg_wdata[2:0];
                    ndr_pkg::REG_BATCH:   batch = cfg_wdata[5:0];
                    ndr_pkg::REG_BUDGET:  budget = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    report("unexpected word seq", m_word.out_seq, -1);
                end else begin
                    want = expected_words.pop_front();
                    if (m_word.kind != want.kind) report("kind", m_word.kind, want.kind);
                    if (m_word.out_seq != want.out_seq)
                        report("out_seq", m_word.out_seq, want.out_seq);
                    if (m_word.nack_count != want.nack_count)
                        report("nack_count", m_word.nack_count, want.nack_count);
                    if (m_word.last != want.last) report("last", m_word.last, want.last);
                end
            end
            if (s_valid && s_ready) predict_words(s_word);
            if (drain && !drained) begin
                drained = 1;
                if (expected_words.size() != 0)
                    report("words never delivered", 0, expected_words.size());
            end
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// tb: stimulus and verdict for the nack dedup receiver
// depends on ndr_pkg, nack_dedup_receiver_top and ndr_checker

module tb;

    // cycle limit: clearing sweep plus many slow ticks, with a wide margin
    localparam int CYCLE_LIMIT = 2000000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    ndr_pkg::in_word_t   s_word;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ndr_pkg::out_word_t  m_word;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [ndr_pkg::CFG_W-1:0] cfg_wdata;
    logic                drain;

    int                  fail_count;
    int                  pending;
    int                  words_seen;
    int                  cycles = 0;
    int                  items_sent;
    int                  burst_left;
    int                  hold_cycles = 0;
    bit                  hold_go;
    bit                  hold_done = 1'b0;
    int unsigned         next_seq;
    logic [31:0]         now_cur;

    nack_dedup_receiver_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    ndr_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .drain(drain), .fail_count(fail_count), .pending(pending),
        .words_seen(words_seen)
    );

    // 4 ns clock
    always #2 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stall pattern cycles through four modes, plus one long hold-off
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_cycles <= 600;
            m_ready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 0;
        end else begin
            case ((cycles / 64) % 4)
                0: m_ready <= 1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // offer one word, bursts of random length with random gaps in between
    task automatic send_word(input logic req, input logic [11:0] len,
                             input logic [15:0] seq, input logic [31:0] now);
        if (burst_left == 0) begin
            if (s_valid) s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1;
        s_word <= '{req_type: req, datagram_len: len, seq: seq, now_us: now};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // wait for the block to go quiet: nothing expected and input ready again
    task automatic settle();
        if (s_valid) s_valid <= 0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= ndr_pkg::CFG_W'(val);
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic load_regs(input int unsigned pd, input int unsigned fp,
                             input int unsigned rtt, input int unsigned rn,
                             input int unsigned mx, input int unsigned bl,
                             input int unsigned bg);
        write_reg(ndr_pkg::REG_PLAYOUT, pd);
        write_reg(ndr_pkg::REG_PERIOD, fp);
        write_reg(ndr_pkg::REG_MIN_RTT, rtt);
        write_reg(ndr_pkg::REG_RENACK, rn);
        write_reg(ndr_pkg::REG_MAX_NK, mx);
        write_reg(ndr_pkg::REG_BATCH, bl);
        write_reg(ndr_pkg::REG_BUDGET, bg);
    endtask

    // mostly in-order good datagrams with holes, ticks on a rising clock, some noise
    task automatic random_phase(input int n);
        int          r;
        int unsigned s;
        logic [11:0] len;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 9) < 2) begin
                    // late arrival: fills a hole or repeats
                    s = $urandom_range(next_seq > 20 ? next_seq - 20 : 0, next_seq);
                end else begin
                    next_seq += $urandom_range(1, 4);
                    s = next_seq;
                end
                send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'(s), $urandom);
            end else if (r < 83) begin
                now_cur += $urandom_range(0, 20000);
                send_word(ndr_pkg::REQ_TICK, 12'($urandom_range(0, 2048)),
                          16'($urandom), now_cur);
            end else if (r < 85) begin
                // tick at an arbitrary time, may expire every hole
                send_word(ndr_pkg::REQ_TICK, 12'($urandom_range(0, 2048)),
                          16'($urandom), $urandom);
            end else begin
                len = 12'($urandom_range(0, 2048));
                if (len == 12'd162) len = 12'd161;
                send_word(ndr_pkg::REQ_DATAGRAM, len, 16'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        aresetn <= 0;
        s_valid <= 0;
        s_word <= '0;
        cfg_we <= 0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        drain <= 0;
        items_sent = 0;
        burst_left = 0;
        hold_go = 0;
        next_seq = 0;
        now_cur = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        // clearing sweep keeps s_ready low
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        load_regs(60000, 20000, 10000, 30000, 4, 32, 320);

        // directed: tick before any datagram, bad lengths, duplicate, holes
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'd0, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd161, 16'd1, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd163, 16'd1, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd0, 16'd2, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd2048, 16'hFFFF, 32'hFFFFFFFF);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'd0, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'd6, 32'd0);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd0);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd1000);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd40000);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'd3, 32'd0);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd80000);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd120000);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd160000);
        send_word(ndr_pkg::REQ_TICK, 12'hFFF, 16'hFFFF, 32'hFFFFFFFF);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'd12, 32'd0);
        send_word(ndr_pkg::REQ_TICK, 12'd0, 16'd0, 32'd0);
        next_seq = 12;
        now_cur = 200000;

        random_phase(35);
        settle();
        // extremes: late deadlines, no rest time, single-entry messages, wide budget
        load_regs(1000000, 65535, 0, 0, 7, 1, 65535);
        hold_go <= 1;
        random_phase(40);
        settle();
        // long rest time, one nack per hole, no budget at all
        load_regs(500000, 30000, 1000000, 1000000, 1, 32, 0);
        random_phase(35);
        settle();
        // no playout delay, short deadlines, small batches
        load_regs(0, 40000, 5000, 20000, 2, 8, 1000);
        now_cur = 0;
        random_phase(40);
        // top sequence numbers last, so no tick has to walk the whole space
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'h8000, 32'd0);
        send_word(ndr_pkg::REQ_DATAGRAM, 12'd162, 16'hFFFF, 32'd0);
        settle();
        repeat (50) @(posedge aclk);
        drain <= 1;
        repeat (2) @(posedge aclk);

        $display("run covered %0d input words and %0d result words over four register settings",
                 items_sent, words_seen);
        $display("with a long receiver hold-off and %0d cycles in all", cycles);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ndr_pkg.sv
rtl/ndr_store.sv
rtl/nack_dedup_receiver_top.sv
verif/ndr_checker.sv
verif/tb.sv
